FILE: src/smm_pkg.sv
// ----------------------------------------------------------------------------
// smm_pkg: shared definitions for the small matrix multiply block
// Field widths, command codes, sequencer states and the control group that
// drives the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package smm_pkg;

    // Default sizing of the element stores.
    localparam int DEF_MAX_DIM    = 16;
    localparam int DEF_ELEM_WIDTH = 32;

    // Fixed widths of the port fields.
    localparam int DATA_W    = 32;
    localparam int CMD_W     = 2;
    localparam int IDX_W     = 4;
    localparam int CFG_W     = 5;
    localparam int FRAC_BITS = 16;

    // Reset value of the inner dimension register.
    localparam logic [CFG_W-1:0] CFG_INNER_RESET = 5'd16;

    // Command codes; the fourth code does nothing.
    localparam logic [CMD_W-1:0] CMD_WRITE_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_FINISH
    } t_state;

    // Control group from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic clear;
        logic valid;
    } t_mac_ctrl;

endpackage

FILE: src/small_matrix_multiply.sv
// A write command does not make the block busy. A compute command holds the command
// channel stalled until its result beat is loaded into the output register;
// out-of-range requests and an effective inner size of zero skip the operand reads.
// No new command is accepted while a compute is in progress, as the single
// multiply-accumulate unit is shared; a stalled result beat holds the block longer.
// Reset clears the sequencer and the output valid, sets inner_size to 16 and leaves
// the element stores undefined until written.
// ----------------------------------------------------------------------------
// small_matrix_multiply: element-at-a-time matrix product engine
// Stores elements of A and B in two memories and returns one element of
// C = A * B per compute command, in signed Q16.16 with saturation.
// ----------------------------------------------------------------------------
module small_matrix_multiply #(
    parameter int MAX_DIM    = smm_pkg::DEF_MAX_DIM,
    parameter int ELEM_WIDTH = smm_pkg::DEF_ELEM_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Command channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [smm_pkg::CMD_W-1:0]          i_cmd,
    input  logic [smm_pkg::IDX_W-1:0]          i_row,
    input  logic [smm_pkg::IDX_W-1:0]          i_col,
    input  logic signed [smm_pkg::DATA_W-1:0]  i_element_value,
    // Result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [smm_pkg::DATA_W-1:0]  o_product_value,
    output logic [smm_pkg::IDX_W-1:0]          o_result_row,
    output logic [smm_pkg::IDX_W-1:0]          o_result_col,
    output logic                               o_saturated,
    // Configuration channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [smm_pkg::CFG_W-1:0]          i_cfg_inner_size
);
    import smm_pkg::*;

    localparam int DEPTH    = MAX_DIM * MAX_DIM;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int K_W      = $clog2(MAX_DIM + 1);
    localparam int ACC_FULL = 2 * ELEM_WIDTH + $clog2(MAX_DIM) + 1;
    localparam int ACC_LEAST = FRAC_BITS + ELEM_WIDTH + 1;
    localparam int ACC_W    = (ACC_FULL > ACC_LEAST) ? ACC_FULL : ACC_LEAST;
    localparam int SH_W     = ACC_W - FRAC_BITS;

    localparam logic signed [ELEM_WIDTH-1:0] ELEM_MAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
    localparam logic signed [ELEM_WIDTH-1:0] ELEM_MIN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

    t_state                        r_state;
    t_state                        n_state;
    logic [CFG_W-1:0]              r_inner_size;
    logic [K_W-1:0]                r_k;
    logic [K_W-1:0]                n_k;
    logic [K_W-1:0]                r_n;
    logic [K_W-1:0]                n_eff;
    logic [IDX_W-1:0]              r_row;
    logic [IDX_W-1:0]              r_col;

    logic                          in_accept;
    logic                          in_range;
    logic                          wr_a;
    logic                          wr_b;
    logic                          start;
    logic                          rd_en;
    logic [ADDR_W-1:0]             wr_addr;
    logic [ADDR_W-1:0]             a_rd_addr;
    logic [ADDR_W-1:0]             b_rd_addr;

    logic signed [ELEM_WIDTH-1:0]  r_a_mem [DEPTH];
    logic signed [ELEM_WIDTH-1:0]  r_b_mem [DEPTH];
    logic signed [ELEM_WIDTH-1:0]  r_a_rd;
    logic signed [ELEM_WIDTH-1:0]  r_b_rd;
    logic                          r_rd_vld;

    t_mac_ctrl                     mac_ctrl;
    logic                          mac_busy;
    logic signed [ACC_W-1:0]       mac_acc;

    logic signed [SH_W-1:0]        acc_shift;
    logic [SH_W-ELEM_WIDTH:0]      acc_upper;
    logic                          sum_ovf;
    logic signed [ELEM_WIDTH-1:0]  sum_sat;

    logic                          r_out_valid;
    logic                          out_free;
    logic                          out_load;

    // Command beat decode.
    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign in_range   = (32'(i_row) < MAX_DIM) && (32'(i_col) < MAX_DIM);
    assign wr_a       = in_accept && (i_cmd == CMD_WRITE_A) && in_range;
    assign wr_b       = in_accept && (i_cmd == CMD_WRITE_B) && in_range;
    assign start      = in_accept && (i_cmd == CMD_COMPUTE);

    // Effective inner size, limited to the store dimension.
    assign n_eff = (32'(r_inner_size) > MAX_DIM) ? K_W'(MAX_DIM) : K_W'(r_inner_size);

    // Configuration register; always ready, as a compute captures its inner size
    // when it starts.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner_size <= CFG_INNER_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_inner_size <= i_cfg_inner_size;
        end
    end

    // Store addresses: row-major, A walks along a row, B down a column.
    assign wr_addr   = ADDR_W'(i_row * MAX_DIM + i_col);
    assign a_rd_addr = ADDR_W'(r_row * MAX_DIM + r_k);
    assign b_rd_addr = ADDR_W'(r_k * MAX_DIM + r_col);

    // Element store for A, one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (wr_a) begin
            r_a_mem[wr_addr] <= i_element_value[ELEM_WIDTH-1:0];
        end
        if (rd_en) begin
            r_a_rd <= r_a_mem[a_rd_addr];
        end
    end

    // Element store for B.
    always_ff @(posedge i_clk) begin
        if (wr_b) begin
            r_b_mem[wr_addr] <= i_element_value[ELEM_WIDTH-1:0];
        end
        if (rd_en) begin
            r_b_rd <= r_b_mem[b_rd_addr];
        end
    end

    // Request capture at the start of a compute.
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_row <= i_row;
            r_col <= i_col;
            r_n   <= n_eff;
        end
    end

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_k      <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_k      <= n_k;
            r_rd_vld <= rd_en;
        end
    end

    // Sequencer: issue one operand pair per cycle, drain the unit, deliver.
    always_comb begin
        n_state        = r_state;
        n_k            = r_k;
        rd_en          = 1'b0;
        out_load       = 1'b0;
        mac_ctrl.clear = 1'b0;
        mac_ctrl.valid = r_rd_vld;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    mac_ctrl.clear = 1'b1;
                    n_k            = '0;
                    if (in_range && (n_eff != '0)) begin
                        n_state = S_RUN;
                    end else begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_RUN: begin
                rd_en = 1'b1;
                n_k   = r_k + K_W'(1);
                if (r_k == r_n - K_W'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_rd_vld && !mac_busy) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Shared multiply-accumulate unit.
    smm_mac #(
        .ELEM_WIDTH (ELEM_WIDTH),
        .ACC_W      (ACC_W)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (mac_ctrl),
        .i_a     (r_a_rd),
        .i_b     (r_b_rd),
        .o_busy  (mac_busy),
        .o_acc   (mac_acc)
    );

    // Drop the fraction bits (floor) and clip to the element range.
    assign acc_shift = SH_W'(mac_acc >>> FRAC_BITS);
    assign acc_upper = acc_shift[SH_W-1:ELEM_WIDTH-1];
    assign sum_ovf   = !((&acc_upper) || !(|acc_upper));
    assign sum_sat   = sum_ovf ? (acc_shift[SH_W-1] ? ELEM_MIN : ELEM_MAX)
                               : acc_shift[ELEM_WIDTH-1:0];

    // Output register: holds a result beat until the receiver takes it.
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_product_value <= DATA_W'(sum_sat);
            o_result_row    <= r_row;
            o_result_col    <= r_col;
            o_saturated     <= sum_ovf;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: src/smm_mac.sv
// ----------------------------------------------------------------------------
// smm_mac: shared multiply-accumulate unit
// One signed multiply per cycle into a product register, then an exact add
// into a wide accumulator that is cleared at the start of each dot product.
// ----------------------------------------------------------------------------
module smm_mac #(
    parameter int ELEM_WIDTH = smm_pkg::DEF_ELEM_WIDTH,
    parameter int ACC_W      = 2 * smm_pkg::DEF_ELEM_WIDTH + 5
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  smm_pkg::t_mac_ctrl             i_ctrl,
    input  logic signed [ELEM_WIDTH-1:0]   i_a,
    input  logic signed [ELEM_WIDTH-1:0]   i_b,
    output logic                           o_busy,
    output logic signed [ACC_W-1:0]        o_acc
);
    import smm_pkg::*;

    logic signed [2*ELEM_WIDTH-1:0] r_prod;
    logic                           r_prod_vld;
    logic signed [ACC_W-1:0]        r_acc;

    // Product stage: a register after the multiplier.
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    // Product valid tracks the operand beat and is dropped on clear.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctrl.valid;
        end
    end

    // Accumulate stage: the sign-extended product is added exactly.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctrl.clear) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_busy = r_prod_vld;
    assign o_acc  = r_acc;

endmodule

FILE: src/smm_checker.sv
// ----------------------------------------------------------------------------
// smm_checker: port-level checks for the small matrix multiply block
// Watches the command and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module smm_checker #(
    parameter int ELEM_WIDTH = smm_pkg::DEF_ELEM_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               o_in_stall,
    input  logic [smm_pkg::CMD_W-1:0]          i_cmd,
    input  logic                               o_out_valid,
    input  logic                               i_out_stall,
    input  logic signed [smm_pkg::DATA_W-1:0]  o_product_value,
    input  logic [smm_pkg::IDX_W-1:0]          o_result_row,
    input  logic [smm_pkg::IDX_W-1:0]          o_result_col,
    input  logic                               o_saturated
);
    import smm_pkg::*;

    localparam logic [DATA_W-1:0] SAT_MAX =
        {{(DATA_W-ELEM_WIDTH+1){1'b0}}, {(ELEM_WIDTH-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = ~SAT_MAX;

    // A stalled result beat stays presented with its payload unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_product_value) && $stable(o_result_row)
             && $stable(o_result_col) && $stable(o_saturated)))
        else $error("result beat changed while stalled");

    // A compute beat makes the block busy on the next cycle.
    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_cmd == CMD_COMPUTE)) |=> o_in_stall)
        else $error("command channel not stalled after a compute beat");

    // A store write never produces a result beat.
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !o_out_valid &&
         ((i_cmd == CMD_WRITE_A) || (i_cmd == CMD_WRITE_B))) |=> !o_out_valid)
        else $error("result beat appeared after a store write");

    // A new result only appears at the end of a busy compute.
    a_result_from_compute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result beat without a compute in progress");

    // A clipped result carries one of the two range limits.
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
            ((o_product_value == SAT_MAX) || (o_product_value == SAT_MIN)))
        else $error("saturated result is not a range limit");

endmodule

bind small_matrix_multiply smm_checker #(
    .ELEM_WIDTH (ELEM_WIDTH)
) u_smm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .i_cmd           (i_cmd),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_product_value (o_product_value),
    .o_result_row    (o_result_row),
    .o_result_col    (o_result_col),
    .o_saturated     (o_saturated)
);

FILE: tb/small_matrix_multiply_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// small_matrix_multiply_checker: result predictor and scoreboard
// Watches the command, configuration and result channels of the matrix
// multiply block. It keeps its own copy of both element stores and of the
// inner dimension, predicts one product element per compute beat, and
// compares every result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module small_matrix_multiply_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Command channel
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  logic [smm_pkg::CMD_W-1:0]          i_cmd,
    input  logic [smm_pkg::IDX_W-1:0]          i_row,
    input  logic [smm_pkg::IDX_W-1:0]          i_col,
    input  logic signed [smm_pkg::DATA_W-1:0]  i_element_value,
    // Result channel
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic signed [smm_pkg::DATA_W-1:0]  i_product_value,
    input  logic [smm_pkg::IDX_W-1:0]          i_result_row,
    input  logic [smm_pkg::IDX_W-1:0]          i_result_col,
    input  logic                               i_saturated,
    // Configuration channel
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic [smm_pkg::CFG_W-1:0]          i_cfg_inner_size,
    // Status for the testbench top
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import smm_pkg::*;

    localparam int DIM   = DEF_MAX_DIM;
    localparam int ACC_W = 72;

    // Bounds of a Q16.16 element, held at the width of the scaled sum.
    localparam logic signed [ACC_W-FRAC_BITS-1:0] SUM_MAX = 56'sd2147483647;
    localparam logic signed [ACC_W-FRAC_BITS-1:0] SUM_MIN = -(56'sd2147483648);

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic                     sat;
    } t_product;

    logic signed [DATA_W-1:0] a_elems [DIM*DIM];
    logic signed [DATA_W-1:0] b_elems [DIM*DIM];
    logic [CFG_W-1:0]         inner_size;
    t_product                 product_queue [$];

    // Exact dot product of an A row and a B column, floored to Q16.16 and
    // clipped to the element range.
    function automatic t_product predict_element(input logic [IDX_W-1:0] row,
                                                 input logic [IDX_W-1:0] col);
        logic signed [ACC_W-1:0]          acc;
        logic signed [ACC_W-1:0]          a_wide;
        logic signed [ACC_W-1:0]          b_wide;
        logic signed [ACC_W-FRAC_BITS-1:0] scaled;
        int                               terms;
        t_product                         res;
        terms = (inner_size > DIM) ? DIM : inner_size;
        acc   = '0;
        for (int k = 0; k < terms; k++) begin
            a_wide = a_elems[row*DIM + k];
            b_wide = b_elems[k*DIM + col];
            acc    = acc + a_wide * b_wide;
        end
        scaled  = acc[ACC_W-1:FRAC_BITS];
        res.row = row;
        res.col = col;
        if (scaled > SUM_MAX) begin
            res.value = 32'sh7FFF_FFFF;
            res.sat   = 1'b1;
        end else if (scaled < SUM_MIN) begin
            res.value = 32'sh8000_0000;
            res.sat   = 1'b1;
        end else begin
            res.value = scaled[DATA_W-1:0];
            res.sat   = 1'b0;
        end
        return res;
    endfunction

    task automatic note_mismatch(input string field, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
        $display("%0t: %s mismatch, expected 0x%h, got 0x%h", $time, field, want, got);
        o_fail_count++;
    endtask

    // Track every handshake at the rising edge; results are checked before
    // new commands are applied.
    always @(posedge i_clk) begin
        t_product want;
        if (!i_rst_n) begin
            inner_size   = CFG_INNER_RESET;
            o_fail_count = 0;
            product_queue.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (product_queue.size() == 0) begin
                    $display("%0t: result beat row %0d col %0d value 0x%h with none expected",
                             $time, i_result_row, i_result_col, i_product_value);
                    o_fail_count++;
                end else begin
                    want = product_queue.pop_front();
                    if (i_product_value !== want.value)
                        note_mismatch("product_value", want.value, i_product_value);
                    if (i_result_row !== want.row)
                        note_mismatch("result_row", DATA_W'(want.row),
                                      DATA_W'(i_result_row));
                    if (i_result_col !== want.col)
                        note_mismatch("result_col", DATA_W'(want.col),
                                      DATA_W'(i_result_col));
                    if (i_saturated !== want.sat)
                        note_mismatch("saturated", DATA_W'(want.sat),
                                      DATA_W'(i_saturated));
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                inner_size = i_cfg_inner_size;
            if (i_in_valid && !i_in_stall) begin
                case (i_cmd)
                    CMD_WRITE_A: a_elems[{i_row, i_col}] = i_element_value;
                    CMD_WRITE_B: b_elems[{i_row, i_col}] = i_element_value;
                    CMD_COMPUTE: product_queue.push_back(predict_element(i_row, i_col));
                    default: ;
                endcase
            end
        end
        o_pending = product_queue.size();
    end

endmodule

FILE: tb/small_matrix_multiply_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// small_matrix_multiply_tb: testbench for the small matrix multiply block
// Loads elements of A and B, requests product elements and changes the
// inner dimension between phases. A short directed part covers saturation,
// rounding, the unused command and an empty sum; random phases follow with
// random gaps on both channels and one long result hold-off.
// ----------------------------------------------------------------------------
module small_matrix_multiply_tb;
    import smm_pkg::*;

    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
    localparam int DIM           = DEF_MAX_DIM;
    localparam int SETTLE_CYCLES = 30;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 700;
    localparam int PHASE_BEATS   = 130;
    localparam int PHASES        = 8;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [CMD_W-1:0]          cmd = CMD_NOP;
    logic [IDX_W-1:0]          row = '0;
    logic [IDX_W-1:0]          col = '0;
    logic signed [DATA_W-1:0]  element_value = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [DATA_W-1:0]  product_value;
    logic [IDX_W-1:0]          result_row;
    logic [IDX_W-1:0]          result_col;
    logic                      saturated;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_W-1:0]          cfg_inner_size = CFG_INNER_RESET;
    int                        fail_count;
    int                        pending;

    // Stimulus bookkeeping: which store entries hold data, the current
    // inner dimension, and how many command beats have gone in.
    bit                        a_written [DIM*DIM];
    bit                        b_written [DIM*DIM];
    logic [CFG_W-1:0]          cur_inner = CFG_INNER_RESET;
    int                        beats_sent = 0;
    bit                        no_idle = 1'b0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    small_matrix_multiply i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_cmd            (cmd),
        .i_row            (row),
        .i_col            (col),
        .i_element_value  (element_value),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_product_value  (product_value),
        .o_result_row     (result_row),
        .o_result_col     (result_col),
        .o_saturated      (saturated),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_inner_size (cfg_inner_size)
    );

    small_matrix_multiply_checker i_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_cmd            (cmd),
        .i_row            (row),
        .i_col            (col),
        .i_element_value  (element_value),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_product_value  (product_value),
        .i_result_row     (result_row),
        .i_result_col     (result_col),
        .i_saturated      (saturated),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_inner_size (cfg_inner_size),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // Idle length: mostly none, sometimes a short one, rarely a long one.
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Element values: mostly small numbers whose sums stay in range, some
    // fully random patterns and some edge values.
    function automatic logic [DATA_W-1:0] rand_element();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        if (r < 80) return $urandom();
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'h0001_0000;
            default: return 32'h0000_0001;
        endcase
    endfunction

    // Offer one command beat, hold it until accepted, then idle at random.
    task automatic send_beat(input logic [CMD_W-1:0] cmd_v, input logic [IDX_W-1:0] row_v,
                             input logic [IDX_W-1:0] col_v,
                             input logic [DATA_W-1:0] value_v);
        int gap;
        @(negedge clk);
        cmd           = cmd_v;
        row           = row_v;
        col           = col_v;
        element_value = value_v;
        in_valid      = 1'b1;
        do @(posedge clk); while (in_stall);
        beats_sent++;
        if (cmd_v == CMD_WRITE_A)
            a_written[{row_v, col_v}] = 1'b1;
        else if (cmd_v == CMD_WRITE_B)
            b_written[{row_v, col_v}] = 1'b1;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // A compute request, preceded by loads of any operand not yet written so
    // that no undefined store entry is ever read.
    task automatic issue_compute(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c);
        int terms;
        terms = (cur_inner > DIM) ? DIM : cur_inner;
        for (int k = 0; k < terms; k++) begin
            if (!a_written[r*DIM + k])
                send_beat(CMD_WRITE_A, r, IDX_W'(k), rand_element());
            if (!b_written[k*DIM + c])
                send_beat(CMD_WRITE_B, IDX_W'(k), c, rand_element());
        end
        send_beat(CMD_COMPUTE, r, c, $urandom());
    endtask

    // Drop the command valid and wait until every predicted result has come
    // back, then allow the last write beats to drain.
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_inner(input logic [CFG_W-1:0] size_v);
        @(negedge clk);
        cfg_valid      = 1'b1;
        cfg_inner_size = size_v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        cur_inner = size_v;
    endtask

    // Result side: random stall stretches, one long hold-off once the
    // command stream is well under way, and none in the quiet phase.
    initial begin
        int  stall_left;
        int  free_left;
        int  hold_left;
        bit  hold_done;
        stall_left = 0;
        free_left  = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                out_stall = 1'b1;
                hold_left--;
            end else if (!hold_done && beats_sent >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_stall = 1'b1;
            end else if (no_idle) begin
                out_stall = 1'b0;
            end else if (stall_left > 0) begin
                out_stall = 1'b1;
                stall_left--;
            end else if (free_left > 0) begin
                out_stall = 1'b0;
                free_left--;
            end else begin
                free_left  = pick_gap();
                stall_left = pick_gap();
                out_stall  = 1'b0;
            end
        end
    end

    // Command stimulus and verdict.
    initial begin
        logic [CFG_W-1:0] settings [PHASES];
        int unsigned      r;
        settings = '{5'd16, 5'd31, 5'd3, 5'd0, 5'd17, 5'd1, 5'd9, 5'd16};
        settings[6] = CFG_W'($urandom_range(2, 15));
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Single-term products: both saturation directions, flooring of a
        // negative sum, a plain product at the far corner, the unused command.
        write_inner(5'd1);
        send_beat(CMD_WRITE_A, 4'd0, 4'd0, 32'h7FFF_FFFF);
        send_beat(CMD_WRITE_B, 4'd0, 4'd0, 32'h7FFF_FFFF);
        send_beat(CMD_COMPUTE, 4'd0, 4'd0, 32'h0);
        send_beat(CMD_WRITE_B, 4'd0, 4'd0, 32'h8000_0000);
        send_beat(CMD_COMPUTE, 4'd0, 4'd0, 32'hFFFF_FFFF);
        send_beat(CMD_WRITE_A, 4'd0, 4'd0, 32'h8000_0000);
        send_beat(CMD_COMPUTE, 4'd0, 4'd0, 32'h0);
        send_beat(CMD_WRITE_A, 4'd0, 4'd0, 32'h0000_0001);
        send_beat(CMD_WRITE_B, 4'd0, 4'd0, 32'hFFFF_FFFF);
        send_beat(CMD_COMPUTE, 4'd0, 4'd0, 32'h0);
        send_beat(CMD_WRITE_A, 4'd15, 4'd0, 32'h0001_0000);
        send_beat(CMD_WRITE_B, 4'd0, 4'd15, 32'hFFFF_0000);
        send_beat(CMD_COMPUTE, 4'd15, 4'd15, 32'h0);
        send_beat(CMD_NOP, 4'd15, 4'd15, 32'hFFFF_FFFF);
        send_beat(CMD_NOP, 4'd0, 4'd0, 32'h0);
        send_beat(CMD_COMPUTE, 4'd0, 4'd15, 32'h0);

        // An inner dimension of zero gives an empty sum.
        settle();
        write_inner(5'd0);
        send_beat(CMD_COMPUTE, 4'd7, 4'd9, 32'h0);
        send_beat(CMD_COMPUTE, 4'd15, 4'd15, 32'hFFFF_FFFF);
        send_beat(CMD_COMPUTE, 4'd0, 4'd0, 32'h0);

        // Random phases, each with its own inner dimension.
        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_inner(settings[p]);
            no_idle = (p == 2);
            for (int i = 0; i < PHASE_BEATS; i++) begin
                r = $urandom_range(0, 99);
                if (r < 45)
                    issue_compute(IDX_W'($urandom_range(0, DIM-1)),
                                  IDX_W'($urandom_range(0, DIM-1)));
                else if (r < 90)
                    send_beat((r < 67) ? CMD_WRITE_A : CMD_WRITE_B,
                              IDX_W'($urandom_range(0, DIM-1)),
                              IDX_W'($urandom_range(0, DIM-1)),
                              rand_element());
                else
                    send_beat(CMD_NOP, IDX_W'($urandom()), IDX_W'($urandom()),
                              $urandom());
            end
        end
        no_idle = 1'b0;

        settle();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
src/smm_pkg.sv
src/smm_mac.sv
src/small_matrix_multiply.sv
src/smm_checker.sv
tb/small_matrix_multiply_checker.sv
tb/small_matrix_multiply_tb.sv
